[hdl/modexp_pkg.sv]
`timescale 1ns / 1ps

package modexp_pkg;

  localparam int unsigned OPERAND_WIDTH = 31;

  typedef logic [OPERAND_WIDTH-1:0] operand_t;

  typedef struct packed {
    operand_t base_value;
    operand_t exponent_value;
    operand_t modulus_value;
  } modexp_in_t;

  typedef struct packed {
    operand_t power_result;
    logic     bad_operand;
  } modexp_out_t;

  // (x + y) mod m for x, y < m
  function automatic operand_t add_mod(operand_t x, operand_t y, operand_t m);
    logic [OPERAND_WIDTH:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
    return sum[OPERAND_WIDTH-1:0];
  endfunction

endpackage

[hdl/modexp_mulmod.sv]
`timescale 1ns / 1ps

module modexp_mulmod import modexp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  operand_t addend_i,
  input  operand_t mplier_i,
  input  operand_t modulus_i,
  output logic     done_o,
  output operand_t product_o
);

  localparam int unsigned CntW = $clog2(OPERAND_WIDTH);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  operand_t        addend_q;
  operand_t        mplier_q;
  operand_t        acc_q;
  operand_t        dbl;
  operand_t        acc_d;

  // Interleaved reduction: double, then add the addend when the multiplier bit is set
  always_comb begin
    dbl   = add_mod(acc_q, acc_q, modulus_i);
    acc_d = mplier_q[OPERAND_WIDTH-1] ? add_mod(dbl, addend_q, modulus_i) : dbl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(OPERAND_WIDTH - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      addend_q <= addend_i;
      mplier_q <= mplier_i;
      acc_q    <= '0;
    end else if (busy_q) begin
      acc_q    <= acc_d;
      mplier_q <= {mplier_q[OPERAND_WIDTH-2:0], 1'b0};
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

[hdl/modular_exponentiation_unit.sv]
`timescale 1ns / 1ps
// Modular exponentiation, right-to-left square and multiply.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes base, exponent and
// modulus; output channel (out_valid_o / out_ready_i / out_data_o) returns one
// item per input: the power and a flag for a zero base or zero modulus.
// One item is worked on at a time; in_ready_o is high only while idle.
// All products go through one shared bit-serial modular multiplier that
// retires one multiplier bit per cycle. For an item with k significant
// exponent bits, p of them set, the work after acceptance is one pass that
// reduces the base, then one multiply per set bit and one square per bit
// below the top. in_ready_o rises again in the cycle in which the result is
// loaded into the output register. Zero base, zero modulus or zero exponent
// skip the multiplier and go straight to the finish state.
// The result sits in an output register; a new item is accepted while it
// waits, and the next result waits for the register to empty.
// Reset clears the state machine and drops any pending result.
module modular_exponentiation_unit import modexp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  modexp_in_t  in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output modexp_out_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL_ACC,
    ST_SQUARE,
    ST_FINISH
  } state_e;

  state_e      state_q, state_d;
  operand_t    base_q, base_d;
  operand_t    exp_q, exp_d;
  operand_t    mod_q, mod_d;
  operand_t    acc_q, acc_d;
  logic        bad_q, bad_d;
  logic        out_valid_q, out_valid_d;
  modexp_out_t out_q, out_d;

  logic        mul_start;
  operand_t    mul_addend;
  operand_t    mul_mplier;
  logic        mul_done;
  operand_t    mul_product;
  operand_t    exp_next;

  modexp_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .addend_i  (mul_addend),
    .mplier_i  (mul_mplier),
    .modulus_i (mod_q),
    .done_o    (mul_done),
    .product_o (mul_product)
  );

  assign exp_next = exp_q >> 1;

  always_comb begin
    state_d     = state_q;
    base_d      = base_q;
    exp_d       = exp_q;
    mod_d       = mod_q;
    acc_d       = acc_q;
    bad_d       = bad_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mul_start   = 1'b0;
    mul_addend  = acc_q;
    mul_mplier  = mul_product;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          base_d = in_data_i.base_value;
          exp_d  = in_data_i.exponent_value;
          mod_d  = in_data_i.modulus_value;
          bad_d  = 1'b0;
          if (in_data_i.base_value == '0 || in_data_i.modulus_value == '0) begin
            bad_d   = 1'b1;
            acc_d   = '0;
            state_d = ST_FINISH;
          end else if (in_data_i.exponent_value == '0) begin
            acc_d   = operand_t'(1);
            state_d = ST_FINISH;
          end else begin
            // 1 mod m, and reduce the base as 1 * base mod m
            acc_d      = (in_data_i.modulus_value == operand_t'(1)) ? '0 : operand_t'(1);
            mul_start  = 1'b1;
            mul_addend = operand_t'(1);
            mul_mplier = in_data_i.base_value;
            state_d    = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mul_done) begin
          base_d    = mul_product;
          mul_start = 1'b1;
          if (exp_q[0]) begin
            state_d = ST_MUL_ACC;
          end else begin
            mul_addend = mul_product;
            state_d    = ST_SQUARE;
          end
        end
      end
      ST_MUL_ACC: begin
        if (mul_done) begin
          acc_d = mul_product;
          if (exp_next == '0) begin
            state_d = ST_FINISH;
          end else begin
            mul_start  = 1'b1;
            mul_addend = base_q;
            mul_mplier = base_q;
            state_d    = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: begin
        if (mul_done) begin
          base_d = mul_product;
          exp_d  = exp_next;
          if (exp_next == '0) begin
            state_d = ST_FINISH;
          end else begin
            mul_start = 1'b1;
            if (exp_next[0]) begin
              state_d = ST_MUL_ACC;
            end else begin
              mul_addend = mul_product;
              state_d    = ST_SQUARE;
            end
          end
        end
      end
      ST_FINISH: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d.power_result = acc_q;
          out_d.bad_operand  = bad_q;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    exp_q  <= exp_d;
    mod_q  <= mod_d;
    acc_q  <= acc_d;
    bad_q  <= bad_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import modexp_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int NUM_RANDOM     = 1180;
  localparam int HOLD_AT_RESULT = 200;
  localparam int HOLD_CYCLES    = 3000;
  localparam int DRAIN_CYCLES   = 2500;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int REPORT_LIMIT   = 10;

  localparam operand_t OP_MAX = '1;

  typedef logic [2*OPERAND_WIDTH-1:0] wide_t;

  typedef struct packed {
    modexp_in_t  stim;
    logic        typed;
    modexp_out_t want;
  } dir_row_t;

  typedef struct packed {
    modexp_in_t  stim;
    modexp_out_t want;
  } pending_power_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  modexp_in_t  in_data    = '0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  modexp_out_t out_data;

  // typed expectation travels with the item, so the monitor sees it at acceptance
  logic        want_typed = 1'b0;
  modexp_out_t want_fixed = '0;

  pending_power_t power_q [$];
  int mismatch_count = 0;
  int idle_cycles    = 0;
  int sent_count     = 0;

  modular_exponentiation_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // base^exponent mod modulus by right-to-left square and multiply, double-width products
  function automatic modexp_out_t predict_power(modexp_in_t item);
    modexp_out_t res;
    wide_t       acc;
    wide_t       sq;
    wide_t       m;
    operand_t    e;
    res = '0;
    if (item.base_value == '0 || item.modulus_value == '0) begin
      res.bad_operand = 1'b1;
      return res;
    end
    if (item.exponent_value == '0) begin
      res.power_result = operand_t'(1);
      return res;
    end
    m   = wide_t'(item.modulus_value);
    acc = wide_t'(1) % m;
    sq  = wide_t'(item.base_value) % m;
    e   = item.exponent_value;
    while (e != '0) begin
      if (e[0]) begin
        acc = (acc * sq) % m;
      end
      sq = (sq * sq) % m;
      e  = e >> 1;
    end
    res.power_result = acc[OPERAND_WIDTH-1:0];
    return res;
  endfunction

  function automatic dir_row_t row(operand_t b, operand_t e, operand_t m, logic typed,
                                   operand_t p, logic bad);
    dir_row_t r;
    r.stim.base_value     = b;
    r.stim.exponent_value = e;
    r.stim.modulus_value  = m;
    r.typed               = typed;
    r.want.power_result   = p;
    r.want.bad_operand    = bad;
    return r;
  endfunction

  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endtask

  // random idle gap before each item, none during burst stretches; valid held across back-to-back items
  task automatic send_item(modexp_in_t item, logic typed, modexp_out_t want);
    int gap;
    gap = ((sent_count / 64) % 5 == 4) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= item;
    want_typed <= typed;
    want_fixed <= want;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  always @(posedge clk) begin
    pending_power_t entry;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        entry.stim = in_data;
        entry.want = want_typed ? want_fixed : predict_power(in_data);
        power_q.push_back(entry);
      end
      if (out_valid && out_ready) begin
        if (power_q.size() == 0) begin
          note_failure($sformatf("unexpected item: power %0d bad %0b",
                                 out_data.power_result, out_data.bad_operand));
        end else begin
          entry = power_q.pop_front();
          if (out_data.power_result !== entry.want.power_result ||
              out_data.bad_operand !== entry.want.bad_operand) begin
            note_failure($sformatf(
                "base %0d exp %0d mod %0d: expected power %0d bad %0b, got power %0d bad %0b",
                entry.stim.base_value, entry.stim.exponent_value, entry.stim.modulus_value,
                entry.want.power_result, entry.want.bad_operand,
                out_data.power_result, out_data.bad_operand));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stall per item, burst stretches, one long hold-off to back up the input
  initial begin
    int stall;
    int recv_count;
    recv_count = 0;
    @(posedge rst_n);
    forever begin
      if (recv_count == HOLD_AT_RESULT) begin
        stall = HOLD_CYCLES;
      end else if ((recv_count / 64) % 5 == 2) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 7);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      recv_count++;
    end
  end

  initial begin
    dir_row_t   dir_rows [$];
    modexp_in_t item;
    int         sel;
    int         esz;

    // error checks come before the exponent-zero rule
    dir_rows.push_back(row(0, 5, 7, 1'b1, 0, 1'b1));
    dir_rows.push_back(row(5, 3, 0, 1'b1, 0, 1'b1));
    dir_rows.push_back(row(0, 9, 0, 1'b1, 0, 1'b1));
    dir_rows.push_back(row(0, 0, 0, 1'b1, 0, 1'b1));
    dir_rows.push_back(row(OP_MAX, OP_MAX, 0, 1'b1, 0, 1'b1));
    dir_rows.push_back(row(0, OP_MAX, OP_MAX, 1'b1, 0, 1'b1));
    // zero exponent gives one, not reduced even for modulus one
    dir_rows.push_back(row(3, 0, 7, 1'b1, 1, 1'b0));
    dir_rows.push_back(row(3, 0, 1, 1'b1, 1, 1'b0));
    dir_rows.push_back(row(OP_MAX, 0, OP_MAX, 1'b1, 1, 1'b0));
    // modulus one with a nonzero exponent
    dir_rows.push_back(row(5, 3, 1, 1'b1, 0, 1'b0));
    dir_rows.push_back(row(OP_MAX, OP_MAX, 1, 1'b1, 0, 1'b0));
    // base at or above the modulus, then mixed cases; the last four rows use the predicted result
    dir_rows.push_back(row(10, 1, 7, 1'b1, 3, 1'b0));
    dir_rows.push_back(row(OP_MAX, OP_MAX, OP_MAX, 1'b1, 0, 1'b0));
    dir_rows.push_back(row(OP_MAX, OP_MAX, OP_MAX - 31'd1, 1'b1, 1, 1'b0));
    dir_rows.push_back(row(3, 5, 2, 1'b1, 1, 1'b0));
    dir_rows.push_back(row(2, 10, 1000, 1'b1, 24, 1'b0));
    dir_rows.push_back(row(1, OP_MAX, OP_MAX, 1'b1, 1, 1'b0));
    dir_rows.push_back(row(OP_MAX - 31'd1, 2, OP_MAX, 1'b1, 1, 1'b0));
    dir_rows.push_back(row(OP_MAX - 31'd1, OP_MAX, OP_MAX, 1'b1, OP_MAX - 31'd1, 1'b0));
    dir_rows.push_back(row(2, 30, OP_MAX, 1'b1, 31'd1073741824, 1'b0));
    dir_rows.push_back(row(2, 31, OP_MAX, 1'b1, 1, 1'b0));
    dir_rows.push_back(row(7, 13, 11, 1'b0, 0, 1'b0));
    dir_rows.push_back(row(12345, 31'h0555_5555, 1000003, 1'b0, 0, 1'b0));
    dir_rows.push_back(row(31'h2AAA_AAAA, 31'h2AAA_AAAA, 31'h5555_5555, 1'b0, 0, 1'b0));
    dir_rows.push_back(row(31'h5555_5555, 31'h5555_5555, OP_MAX - 31'd2, 1'b0, 0, 1'b0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    end

    // mostly short exponents to keep the run short; about three in twenty use the full width
    for (int n = 0; n < NUM_RANDOM; n++) begin
      sel = $urandom_range(0, 99);
      esz = $urandom_range(0, 19);
      item.base_value    = ($urandom_range(0, 3) == 0) ? operand_t'($urandom_range(1, 1000))
                                                       : operand_t'($urandom());
      item.modulus_value = ($urandom_range(0, 3) == 0) ? operand_t'($urandom_range(1, 1000))
                                                       : operand_t'($urandom());
      if (esz < 13) begin
        item.exponent_value = operand_t'($urandom_range(1, 63));
      end else if (esz < 17) begin
        item.exponent_value = operand_t'($urandom_range(1, 65535));
      end else begin
        item.exponent_value = operand_t'($urandom());
      end
      if (sel < 4) begin
        item.base_value = '0;
      end else if (sel < 8) begin
        item.modulus_value = '0;
      end else if (sel < 12) begin
        item.exponent_value = '0;
      end else if (sel < 16) begin
        item.modulus_value = operand_t'($urandom_range(1, 3));
      end
      send_item(item, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (power_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && power_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[modular_exponentiation_unit.f]
hdl/modexp_pkg.sv
hdl/modexp_mulmod.sv
hdl/modular_exponentiation_unit.sv
sim/tb_top.sv
